// ===== src/cph_pkg.sv =====
// shared constants, types and the arctangent table of the cartesian to polar converter
package cph_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int ANGLE_STEPS = 16;
	localparam int TABLE_LEN   = 24;
	localparam int PRESCALE_SH = 24;

	localparam int RADIUS_W  = 16;
	localparam int HEADING_W = 17;

	localparam int UV_W       = COORD_WIDTH + PRESCALE_SH + 3;
	localparam int Z_W        = 32;
	localparam int ZR_SH      = 16;
	localparam int SQ_W       = 2 * COORD_WIDTH;
	localparam int ROOT_W     = COORD_WIDTH;
	localparam int REM_W      = COORD_WIDTH + 3;
	localparam int SQRT_STEPS = COORD_WIDTH;
	localparam int NUM_CELLS  = (ANGLE_STEPS > SQRT_STEPS) ? ANGLE_STEPS : SQRT_STEPS;
	localparam int STEP_W     = $clog2(NUM_CELLS);
	localparam int TAB_W      = $clog2(TABLE_LEN);

	localparam logic signed [Z_W-1:0] Z_QUARTER  = 32'sh4000_0000;
	localparam logic signed [Z_W-1:0] Z_HALF_LSB = 32'sd32768;

	localparam logic signed [HEADING_W-1:0] HALF_TURN    = 17'sd32768;
	localparam logic signed [HEADING_W-1:0] QUARTER_TURN = 17'sd16384;
	localparam logic signed [HEADING_W-1:0] ZERO_TURN    = 17'sd0;

	typedef logic [2:0] hd_sel_t;

	localparam hd_sel_t HD_CORDIC = 3'd0;
	localparam hd_sel_t HD_UP     = 3'd1;
	localparam hd_sel_t HD_DOWN   = 3'd2;
	localparam hd_sel_t HD_RIGHT  = 3'd3;
	localparam hd_sel_t HD_LEFT   = 3'd4;

	typedef struct packed {
		hd_sel_t sel;
		logic    half;
		logic    neg;
	} cph_ctl_t;

	typedef struct packed {
		logic signed [UV_W-1:0] u;
		logic signed [UV_W-1:0] v;
		logic signed [Z_W-1:0]  z;
		logic [SQ_W-1:0]        sq;
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
		cph_ctl_t               ctl;
	} cph_cell_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [Z_W-1:0] atan_lut(input logic [TAB_W-1:0] idx);
		logic [Z_W-1:0] val;
		case (idx)
			5'd0:    val = 32'h2000_0000;
			5'd1:    val = 32'h12E4_051D;
			5'd2:    val = 32'h09FB_385B;
			5'd3:    val = 32'h0511_11D4;
			5'd4:    val = 32'h028B_0D43;
			5'd5:    val = 32'h0145_D7E1;
			5'd6:    val = 32'h00A2_F61E;
			5'd7:    val = 32'h0051_7C55;
			5'd8:    val = 32'h0028_BE53;
			5'd9:    val = 32'h0014_5F2E;
			5'd10:   val = 32'h000A_2F98;
			5'd11:   val = 32'h0005_17CC;
			5'd12:   val = 32'h0002_8BE6;
			5'd13:   val = 32'h0001_45F3;
			5'd14:   val = 32'h0000_A2F9;
			5'd15:   val = 32'h0000_517C;
			5'd16:   val = 32'h0000_28BE;
			5'd17:   val = 32'h0000_145F;
			5'd18:   val = 32'h0000_0A2F;
			5'd19:   val = 32'h0000_0517;
			5'd20:   val = 32'h0000_028B;
			5'd21:   val = 32'h0000_0145;
			5'd22:   val = 32'h0000_00A2;
			5'd23:   val = 32'h0000_0051;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== src/cph_if.sv =====
// request channels of the cartesian to polar converter
interface cph_point_if import cph_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_pos;
	logic signed [COORD_WIDTH-1:0] y_pos;

	modport source(output valid, output x_pos, output y_pos, input ready);
	modport sink(input valid, input x_pos, input y_pos, output ready);
endinterface

interface cph_polar_if import cph_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [RADIUS_W-1:0]         radius;
	logic signed [HEADING_W-1:0] heading;

	modport source(output valid, output radius, output heading, input ready);
	modport sink(input valid, input radius, input heading, output ready);
endinterface

// ===== src/cph_prep.sv =====
// input stages: squares, magnitudes, special case decode and cell chain seed
module cph_prep import cph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	cph_point_if.sink cart,
	output logic      valid,
	output cph_cell_t stage
);

	logic signed [COORD_WIDTH:0] xe, ye;
	logic [COORD_WIDTH-1:0]      ax, ay;
	cph_ctl_t                    ctl;

	logic                   valid_s1;
	logic [SQ_W-1:0]        sqx_s1, sqy_s1;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1;
	cph_ctl_t               ctl_s1;

	logic      valid_s2;
	cph_cell_t cell_s2;

	assign cart.ready = en;

	always_comb begin
		xe = {cart.x_pos[COORD_WIDTH-1], cart.x_pos};
		ye = {cart.y_pos[COORD_WIDTH-1], cart.y_pos};
		ax = COORD_WIDTH'(xe[COORD_WIDTH] ? -xe : xe);
		ay = COORD_WIDTH'(ye[COORD_WIDTH] ? -ye : ye);
		ctl.half = cart.y_pos[COORD_WIDTH-1];
		ctl.neg  = cart.x_pos[COORD_WIDTH-1] ^ cart.y_pos[COORD_WIDTH-1];
		if (cart.x_pos == '0) begin
			ctl.sel = cart.y_pos[COORD_WIDTH-1] ? HD_DOWN : HD_UP;
		end else if (cart.y_pos == '0) begin
			ctl.sel = cart.x_pos[COORD_WIDTH-1] ? HD_LEFT : HD_RIGHT;
		end else begin
			ctl.sel = HD_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cart.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= SQ_W'(ax) * SQ_W'(ax);
			sqy_s1 <= SQ_W'(ay) * SQ_W'(ay);
			ax_s1  <= ax;
			ay_s1  <= ay;
			ctl_s1 <= ctl;

			cell_s2.u    <= UV_W'({ay_s1, {PRESCALE_SH{1'b0}}});
			cell_s2.v    <= UV_W'({ax_s1, {PRESCALE_SH{1'b0}}});
			cell_s2.z    <= '0;
			cell_s2.sq   <= sqx_s1 + sqy_s1;
			cell_s2.rem  <= '0;
			cell_s2.root <= '0;
			cell_s2.ctl  <= ctl_s1;
		end
	end

	assign valid = valid_s2;
	assign stage = cell_s2;

endmodule

// ===== src/cph_cell.sv =====
// one cordic vectoring step and one square root digit step
module cph_cell import cph_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  logic              src_valid,
	input  cph_cell_t         src,
	output logic              dst_valid,
	output cph_cell_t         dst
);

	cph_cell_t              nxt;
	logic signed [UV_W-1:0] du, dv;
	logic [Z_W-1:0]         ang;
	logic [REM_W-1:0]       rem_sh, trial;

	always_comb begin
		nxt    = src;
		du     = src.v >>> step;
		dv     = src.u >>> step;
		ang    = atan_lut(TAB_W'(step));
		rem_sh = REM_W'({src.rem, src.sq[SQ_W-1 -: 2]});
		trial  = REM_W'({src.root, 2'b01});

		if (int'(step) < ANGLE_STEPS) begin
			if (!src.v[UV_W-1]) begin
				nxt.u = src.u + du;
				nxt.v = src.v - dv;
				nxt.z = src.z + $signed(ang);
			end else begin
				nxt.u = src.u - du;
				nxt.v = src.v + dv;
				nxt.z = src.z - $signed(ang);
			end
		end

		if (int'(step) < SQRT_STEPS) begin
			nxt.sq = {src.sq[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				nxt.rem  = rem_sh - trial;
				nxt.root = {src.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem_sh;
				nxt.root = {src.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst <= nxt;
		end
	end

endmodule

// ===== src/cph_out.sv =====
// final rounding, heading assembly, output register and skid buffer
module cph_out import cph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  cph_cell_t   stage,
	output logic        en,
	cph_polar_if.source polar
);

	logic [ROOT_W:0]             root_rnd;
	logic [RADIUS_W-1:0]         radius_d;
	logic signed [Z_W-1:0]       zc, zr;
	logic [Z_W-ZR_SH-1:0]        ang;
	logic signed [HEADING_W-1:0] ang_s, term, base, heading_d;

	logic                        out_valid_q, skid_full_q;
	logic [RADIUS_W-1:0]         radius_q, radius_skid_q;
	logic signed [HEADING_W-1:0] heading_q, heading_skid_q;

	always_comb begin
		root_rnd = {1'b0, stage.root} + (ROOT_W + 1)'(stage.rem > REM_W'(stage.root));
		radius_d = RADIUS_W'(root_rnd);

		if (stage.z[Z_W-1]) begin
			zc = '0;
		end else if (stage.z > Z_QUARTER) begin
			zc = Z_QUARTER;
		end else begin
			zc = stage.z;
		end
		zr    = zc + Z_HALF_LSB;
		ang   = zr[Z_W-1:ZR_SH];
		ang_s = $signed(HEADING_W'(ang));
		term  = stage.ctl.neg ? -ang_s : ang_s;
		base  = stage.ctl.half ? HALF_TURN : ZERO_TURN;

		case (stage.ctl.sel)
			HD_UP:    heading_d = ZERO_TURN;
			HD_DOWN:  heading_d = HALF_TURN;
			HD_RIGHT: heading_d = QUARTER_TURN;
			HD_LEFT:  heading_d = -QUARTER_TURN;
			default:  heading_d = base + term;
		endcase
	end

	assign en = !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (polar.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (valid) begin
			if (out_valid_q && !polar.ready) begin
				skid_full_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (polar.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (polar.ready) begin
				radius_q  <= radius_skid_q;
				heading_q <= heading_skid_q;
			end
		end else if (valid) begin
			if (out_valid_q && !polar.ready) begin
				radius_skid_q  <= radius_d;
				heading_skid_q <= heading_d;
			end else begin
				radius_q  <= radius_d;
				heading_q <= heading_d;
			end
		end
	end

	assign polar.valid   = out_valid_q;
	assign polar.radius  = radius_q;
	assign polar.heading = heading_q;

endmodule

// ===== src/cartesian_to_polar_heading.sv =====
// cartesian to polar converter: radius and heading from the +y axis
// A point (x_pos, y_pos) enters on the cart channel as a valid/ready request
// and its radius and heading leave on the polar channel, one result per point,
// in the order the points came in.
// Each point passes two input stages (squares, then their sum and the cordic
// seed), one cell per step of the row of 16 cells, each doing one cordic
// rotation and one square root digit, and the output register.
// Throughput is one point per cycle while cart.ready is high; the row of
// cells advances as a whole.
// When the receiver stalls, the output register holds its result and a skid
// register catches the one result already leaving the last cell; only then does
// cart.ready drop, and it rises again in the cycle after the stall ends.
// Reset clears all valid flags and the skid state; the block holds no other
// state, so it is ready for a point in the first cycle after reset.
module cartesian_to_polar_heading import cph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cph_point_if.sink   cart,
	cph_polar_if.source polar
);

	logic      en;
	logic      chain_valid [0:NUM_CELLS];
	cph_cell_t chain       [0:NUM_CELLS];

	cph_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cart   (cart),
		.valid  (chain_valid[0]),
		.stage  (chain[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		cph_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEP_W'(i)),
			.src_valid (chain_valid[i]),
			.src       (chain[i]),
			.dst_valid (chain_valid[i+1]),
			.dst       (chain[i+1])
		);
	end

	cph_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (chain_valid[NUM_CELLS]),
		.stage  (chain[NUM_CELLS]),
		.en     (en),
		.polar  (polar)
	);

endmodule

// ===== tb/cartesian_to_polar_heading_tb.sv =====
// self-checking bench: random and corner points through the converter, radius and heading checked
module cartesian_to_polar_heading_tb import cph_pkg::*; ();

	localparam longint ATAN_STEP [24] = '{
		64'h2000_0000, 64'h12E4_051D, 64'h09FB_385B, 64'h0511_11D4,
		64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
		64'h0028_BE53, 64'h0014_5F2E, 64'h000A_2F98, 64'h0005_17CC,
		64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2F9, 64'h0000_517C,
		64'h0000_28BE, 64'h0000_145F, 64'h0000_0A2F, 64'h0000_0517,
		64'h0000_028B, 64'h0000_0145, 64'h0000_00A2, 64'h0000_0051
	};

	typedef struct {
		logic [RADIUS_W-1:0]         radius;
		logic signed [HEADING_W-1:0] heading;
	} polar_t;

	class polar_board;
		polar_t pending_polar[$];
		int     mismatches = 0;
		int     checked    = 0;
		int     points     = 0;
		int     on_axis    = 0;
		int     lower_half = 0;

		// vectoring rotations on a point in the right half plane, angle in 1/65536 turn
		function automatic longint arc_of(longint u, longint v);
			longint z;
			longint du;
			longint dv;
			z = 0;
			u = u <<< 24;
			v = v <<< 24;
			for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
				du = v >>> i;
				dv = u >>> i;
				if (v >= 0) begin
					u = u + du;
					v = v - dv;
					z = z + ATAN_STEP[i];
				end else begin
					u = u - du;
					v = v + dv;
					z = z - ATAN_STEP[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > (longint'(16384) <<< 16))
				z = longint'(16384) <<< 16;
			return (z + 32768) >>> 16;
		endfunction

		function automatic polar_t polar_of(logic signed [COORD_WIDTH-1:0] x,
				logic signed [COORD_WIDTH-1:0] y);
			polar_t p;
			longint sx;
			longint sy;
			longint s;
			longint r;
			longint u;
			longint v;
			longint base;
			longint a;
			longint h;
			sx = longint'(x);
			sy = longint'(y);
			s = sx * sx + sy * sy;
			r = 0;
			for (int k = 16; k >= 0; k--)
				if ((r | (longint'(1) << k)) * (r | (longint'(1) << k)) <= s)
					r = r | (longint'(1) << k);
			if (s - r * r > r)
				r = r + 1;
			if (sx == 0) begin
				h = (sy < 0) ? longint'(HALF_TURN) : longint'(ZERO_TURN);
			end else if (sy == 0) begin
				h = (sx > 0) ? longint'(QUARTER_TURN) : -longint'(QUARTER_TURN);
			end else begin
				u = sy;
				v = sx;
				base = 0;
				if (sy < 0) begin
					u = -sy;
					v = -sx;
					base = longint'(HALF_TURN);
				end
				a = arc_of(u, (v < 0) ? -v : v);
				h = base + ((v < 0) ? -a : a);
			end
			p.radius = r[RADIUS_W-1:0];
			p.heading = h[HEADING_W-1:0];
			return p;
		endfunction

		function void add_point(logic signed [COORD_WIDTH-1:0] x,
				logic signed [COORD_WIDTH-1:0] y);
			pending_polar.push_back(polar_of(x, y));
			points++;
			if (x == 0 || y == 0)
				on_axis++;
			if (y < 0)
				lower_half++;
		endfunction

		function void check_polar(logic [RADIUS_W-1:0] radius,
				logic signed [HEADING_W-1:0] heading);
			polar_t want;
			if (pending_polar.size() == 0) begin
				$display("%0t: unexpected result radius %0d heading %0d",
					$time, radius, heading);
				mismatches++;
				return;
			end
			want = pending_polar.pop_front();
			checked++;
			if (radius !== want.radius) begin
				$display("%0t: radius expected %0d actual %0d", $time, want.radius, radius);
				mismatches++;
			end
			if (heading !== want.heading) begin
				$display("%0t: heading expected %0d actual %0d",
					$time, want.heading, heading);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;

	cph_point_if cart();
	cph_polar_if polar();

	polar_board board = new();

	cartesian_to_polar_heading dut (
		.clk(clk),
		.arst_n(arst_n),
		.cart(cart),
		.polar(polar)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_point(logic signed [COORD_WIDTH-1:0] x,
			logic signed [COORD_WIDTH-1:0] y);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cart.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cart.valid <= 1'b1;
		cart.x_pos <= x;
		cart.y_pos <= y;
		do
			@(posedge clk);
		while (!cart.ready);
		board.add_point(x, y);
	endtask

	task automatic send_random_point();
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		x = COORD_WIDTH'($urandom);
		y = COORD_WIDTH'($urandom);
		case ($urandom_range(0, 9))
			0, 1: begin
				x = $signed(16'($urandom_range(0, 128))) - 16'sd64;
				y = $signed(16'($urandom_range(0, 128))) - 16'sd64;
			end
			2: begin
				if ($urandom_range(0, 1))
					x = '0;
				else
					y = '0;
			end
			3: begin
				if ($urandom_range(0, 1))
					x = $signed(16'($urandom_range(0, 6))) - 16'sd3;
				else
					y = $signed(16'($urandom_range(0, 6))) - 16'sd3;
			end
			4: begin
				x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end
			5: begin
				y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end
			default: ;
		endcase
		send_point(x, y);
	endtask

	// result side with random stalls
	initial begin
		int stall;
		stall = 0;
		polar.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (polar.valid && polar.ready)
				board.check_polar(polar.radius, polar.heading);
			if (stall > 0) begin
				polar.ready <= 1'b0;
				stall--;
			end else begin
				polar.ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					stall = ($urandom_range(0, 9) == 0) ?
						$urandom_range(8, 40) : $urandom_range(1, 3);
			end
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		calm <= 1'b0;
		cart.valid <= 1'b0;
		cart.x_pos <= '0;
		cart.y_pos <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// origin, axes, extremes, near the axes
		send_point(16'sd0, 16'sd0);
		send_point(16'sd1, 16'sd0);
		send_point(-16'sd1, 16'sd0);
		send_point(16'sd0, 16'sd1);
		send_point(16'sd0, -16'sd1);
		send_point(16'sh7fff, 16'sd0);
		send_point(16'sh8000, 16'sd0);
		send_point(16'sd0, 16'sh7fff);
		send_point(16'sd0, 16'sh8000);
		send_point(16'sh7fff, 16'sh7fff);
		send_point(16'sh8000, 16'sh8000);
		send_point(16'sh7fff, 16'sh8000);
		send_point(16'sh8000, 16'sh7fff);
		send_point(16'sd1, 16'sd1);
		send_point(-16'sd1, -16'sd1);
		send_point(16'sd1, -16'sd1);
		send_point(-16'sd1, 16'sd1);
		send_point(16'sh8000, -16'sd1);
		send_point(16'sh7fff, -16'sd1);
		send_point(16'sh8000, 16'sd1);
		send_point(16'sd1, 16'sh8000);
		send_point(-16'sd1, 16'sh7fff);
		send_point(16'sd48, 16'sd64);
		send_point(-16'sd48, -16'sd64);

		for (int blk = 0; blk < 9; blk++) begin
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 100; n++)
				send_random_point();
		end
		cart.valid <= 1'b0;
		calm = 1'b0;

		while (board.pending_polar.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("checked %0d results from %0d points: %0d on an axis, %0d below the x axis",
			board.checked, board.points, board.on_axis, board.lower_half);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
